>>> sv/pit_pkg.sv
package pit_pkg;

  // table size and field widths
  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  // signed parent link, one bit over the entry index for the -1 root mark
  localparam int PAR_W       = IDX_W + 1;
  localparam int OP_W        = 3;

  typedef logic signed [PAR_W-1:0] par_t;
  typedef logic        [IDX_W-1:0] idx_t;
  typedef logic        [CNT_W-1:0] cnt_t;

  // request codes
  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 3'd0,
    OP_REMOVE   = 3'd1,
    OP_REPARENT = 3'd2,
    OP_QUERY    = 3'd3,
    OP_SETACT   = 3'd4
  } op_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WALK,
    ST_REMOVE
  } state_t;

  // what every cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_REMOVE
  } cell_kind_t;

  // command broadcast along the row
  // write: addr is the entry, data the new parent
  // remove: addr is the removed entry, data its renumbered parent
  typedef struct packed {
    cell_kind_t kind;
    idx_t       addr;
    par_t       data;
  } cell_cmd_t;

endpackage

>>> sv/pit_cell.sv
module pit_cell (
  input  logic                clk,
  input  pit_pkg::idx_t       idx,
  input  pit_pkg::cell_cmd_t  cmd,
  input  pit_pkg::par_t       right,
  output pit_pkg::par_t       parent
);

  pit_pkg::par_t parent_next;
  pit_pkg::par_t src;
  pit_pkg::par_t tgt_s;
  pit_pkg::par_t rp_adj;

  // next parent of this entry
  always_comb begin
    tgt_s  = pit_pkg::par_t'(cmd.addr);
    rp_adj = cmd.data;
    // entries at or above the removed one take their right neighbor
    src    = (idx >= cmd.addr) ? right : parent;
    case (cmd.kind)
      pit_pkg::CELL_WRITE: begin
        parent_next = (idx == cmd.addr) ? cmd.data : parent;
      end
      pit_pkg::CELL_REMOVE: begin
        if (src == tgt_s) begin
          parent_next = rp_adj;
        end else if (src > tgt_s) begin
          parent_next = src - pit_pkg::par_t'(1);
        end else begin
          parent_next = src;
        end
      end
      default: begin
        parent_next = parent;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    parent <= parent_next;
  end

endmodule

>>> sv/pit_row.sv
module pit_row (
  input  logic                clk,
  input  pit_pkg::cell_cmd_t  cmd,
  input  pit_pkg::idx_t       rd_addr,
  output pit_pkg::par_t       rd_data
);

  pit_pkg::par_t vals [pit_pkg::MAX_ENTRIES];

  // row of cells; on remove, each cell at or above the removed entry shifts from its right neighbor
  for (genvar i = 0; i < pit_pkg::MAX_ENTRIES; i++) begin : g_cell
    pit_pkg::par_t right;
    if (i == pit_pkg::MAX_ENTRIES - 1) begin : g_last
      assign right = vals[i];
    end else begin : g_mid
      assign right = vals[i+1];
    end
    pit_cell u_cell (
      .clk    (clk),
      .idx    (pit_pkg::IDX_W'(i)),
      .cmd    (cmd),
      .right  (right),
      .parent (vals[i])
    );
  end

  // parent lookup bus for one entry
  assign rd_data = vals[rd_addr];

endmodule

>>> sv/parent_index_table_core.sv
// Parent-index table: a forest of up to 64 entries kept as parent indices.
// Requests: op, target and other are taken at a rising edge with start high
// and busy low; busy stays high while the request is worked on.
// Each request gives one result: done is high for exactly one cycle with
// ok, result_index, entry_count and active_index valid in that cycle. The
// receiver cannot stall; the result must be taken in that cycle.
// Steps from the accepting edge to the done cycle:
//   add, set active, refused or unknown requests: the decode state only
//   remove: decode (parent lookup), then one parallel shift of the cells at or above it
//   reparent and ancestor query: decode, then a walk that follows one
//   link per cycle over the lookup bus of the cell row.
// A new request can be accepted in the done cycle of the previous one.
// Reset clears the entry count to zero and the active index to -1; the
// cell contents are not cleared and are only read once written.
module parent_index_table_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [pit_pkg::OP_W-1:0]    op,
  input  logic [pit_pkg::IDX_W-1:0]   target,
  input  logic signed [pit_pkg::PAR_W-1:0] other,
  output logic                        done,
  output logic                        ok,
  output logic signed [pit_pkg::PAR_W-1:0] result_index,
  output logic [pit_pkg::CNT_W-1:0]   entry_count,
  output logic signed [pit_pkg::PAR_W-1:0] active_index
);

  pit_pkg::state_t    state, state_next;
  pit_pkg::op_t       op_r;
  pit_pkg::idx_t      tgt_r;
  pit_pkg::par_t      oth_r;
  pit_pkg::par_t      ptr, ptr_next;
  pit_pkg::par_t      wanted, wanted_next;
  pit_pkg::cnt_t      steps, steps_next;
  pit_pkg::cnt_t      count, count_next;
  pit_pkg::par_t      active, active_next;
  logic               done_next;
  logic               ok_r, ok_next;
  pit_pkg::par_t      res_r, res_next;
  pit_pkg::cell_cmd_t cmd;
  pit_pkg::idx_t      rd_addr;
  pit_pkg::par_t      rd_data;

  logic               accept;
  logic               tgt_valid;
  logic               in_range;
  logic               finish;
  pit_pkg::par_t      tgt_s;
  pit_pkg::par_t      minus_one;

  assign accept    = start && (state == pit_pkg::ST_IDLE);
  assign tgt_valid = pit_pkg::cnt_t'(tgt_r) < count;
  assign tgt_s     = pit_pkg::par_t'(tgt_r);
  assign minus_one = '1;
  assign in_range  = !ptr[pit_pkg::PAR_W-1] &&
                     (pit_pkg::cnt_t'($unsigned(ptr)) < count) && (steps <= count);

  pit_row u_row (
    .clk     (clk),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pit_pkg::ST_IDLE: begin
        if (accept) state_next = pit_pkg::ST_DECODE;
      end
      pit_pkg::ST_DECODE: begin
        state_next = pit_pkg::ST_IDLE;
        case (op_r)
          pit_pkg::OP_REMOVE: begin
            if (tgt_valid) state_next = pit_pkg::ST_REMOVE;
          end
          pit_pkg::OP_REPARENT: begin
            if (tgt_valid && (oth_r >= minus_one) && (oth_r != tgt_s) &&
                (oth_r[pit_pkg::PAR_W-1] ||
                 (pit_pkg::cnt_t'($unsigned(oth_r)) < count))) begin
              state_next = pit_pkg::ST_WALK;
            end
          end
          pit_pkg::OP_QUERY: begin
            if (tgt_valid && !oth_r[pit_pkg::PAR_W-1]) state_next = pit_pkg::ST_WALK;
          end
          default: begin
            state_next = pit_pkg::ST_IDLE;
          end
        endcase
      end
      pit_pkg::ST_WALK: begin
        if (!in_range || (ptr == wanted)) state_next = pit_pkg::ST_IDLE;
      end
      pit_pkg::ST_REMOVE: begin
        state_next = pit_pkg::ST_IDLE;
      end
      default: begin
        state_next = pit_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and result values
  always_comb begin
    ptr_next    = ptr;
    wanted_next = wanted;
    steps_next  = steps;
    count_next  = count;
    active_next = active;
    ok_next     = ok_r;
    res_next    = res_r;
    finish      = 1'b0;
    rd_addr     = tgt_r;
    cmd.kind    = pit_pkg::CELL_HOLD;
    cmd.addr    = tgt_r;
    cmd.data    = oth_r;
    case (state)
      pit_pkg::ST_DECODE: begin
        finish   = (state_next == pit_pkg::ST_IDLE);
        ok_next  = 1'b0;
        res_next = minus_one;
        steps_next = '0;
        case (op_r)
          pit_pkg::OP_ADD: begin
            if (count < pit_pkg::cnt_t'(pit_pkg::MAX_ENTRIES)) begin
              cmd.kind = pit_pkg::CELL_WRITE;
              cmd.addr = pit_pkg::idx_t'(count);
              cmd.data = (!oth_r[pit_pkg::PAR_W-1] &&
                          (pit_pkg::cnt_t'($unsigned(oth_r)) < count)) ? oth_r : minus_one;
              count_next = count + pit_pkg::cnt_t'(1);
              res_next   = pit_pkg::par_t'(count);
              ok_next    = 1'b1;
            end
          end
          pit_pkg::OP_REMOVE: begin
            // parent of the removed entry
            ptr_next = rd_data;
          end
          pit_pkg::OP_REPARENT: begin
            ptr_next    = oth_r;
            wanted_next = tgt_s;
          end
          pit_pkg::OP_QUERY: begin
            ptr_next    = rd_data;
            wanted_next = oth_r;
          end
          pit_pkg::OP_SETACT: begin
            active_next = oth_r[pit_pkg::PAR_W-1] ? minus_one : oth_r;
            ok_next     = 1'b1;
          end
          default: begin
            ok_next = 1'b0;
          end
        endcase
      end
      pit_pkg::ST_WALK: begin
        // follow one link per cycle
        rd_addr = pit_pkg::idx_t'($unsigned(ptr));
        if (in_range && (ptr != wanted)) begin
          ptr_next   = rd_data;
          steps_next = steps + pit_pkg::cnt_t'(1);
        end else begin
          finish = 1'b1;
          if (op_r == pit_pkg::OP_REPARENT) begin
            // a hit means the new parent lies under the target
            ok_next = !in_range;
            if (!in_range) begin
              cmd.kind = pit_pkg::CELL_WRITE;
              cmd.addr = tgt_r;
              cmd.data = oth_r;
            end
          end else begin
            ok_next = in_range;
          end
        end
      end
      pit_pkg::ST_REMOVE: begin
        finish     = 1'b1;
        cmd.kind   = pit_pkg::CELL_REMOVE;
        cmd.addr   = tgt_r;
        cmd.data   = (ptr > tgt_s) ? ptr - pit_pkg::par_t'(1) : ptr;
        count_next = count - pit_pkg::cnt_t'(1);
        ok_next    = 1'b1;
        if (active == tgt_s) begin
          active_next = minus_one;
        end else if (active > tgt_s) begin
          active_next = active - pit_pkg::par_t'(1);
        end
      end
      default: begin
        finish = 1'b0;
      end
    endcase
    done_next = finish;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= pit_pkg::ST_IDLE;
      count  <= '0;
      active <= '1;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      active <= active_next;
      done   <= done_next;
    end
  end

  // request capture and walk registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= pit_pkg::op_t'(op);
      tgt_r <= target;
      oth_r <= other;
    end
    ptr    <= ptr_next;
    wanted <= wanted_next;
    steps  <= steps_next;
    ok_r   <= ok_next;
    res_r  <= res_next;
  end

  assign busy         = (state != pit_pkg::ST_IDLE);
  assign ok           = ok_r;
  assign result_index = res_r;
  assign entry_count  = count;
  assign active_index = active;

endmodule

>>> test/tb_parent_index_table_core.sv
module tb_parent_index_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pit_pkg::*;

  // op codes outside the defined set
  localparam logic [OP_W-1:0] OP_BAD_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_BAD_HI = 3'd7;

  localparam int RANDOM_REQUESTS = 1300;
  localparam int CALM_TAIL       = 150;
  localparam int DRAIN_LIMIT     = 500;

  typedef struct packed {
    logic ok;
    par_t res;
    cnt_t cnt;
    par_t act;
  } outcome_t;

  typedef struct {
    logic [OP_W-1:0] op;
    int              tgt;
    int              oth;
    bit              typed;
    outcome_t        want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [OP_W-1:0]   op = OP_ADD;
  idx_t              target = '0;
  par_t              other = '0;
  logic              busy;
  logic              done;
  logic              ok;
  par_t              result_index;
  cnt_t              entry_count;
  par_t              active_index;

  // shadow copy of the forest
  par_t fparent [MAX_ENTRIES];
  int   fcount = 0;
  int   factive = -1;

  outcome_t outcome_q[$];
  int errors = 0;
  int requests = 0;
  int peak_count = 0;
  int full_refusals = 0;
  int reparent_refusals = 0;

  always #10 clk = ~clk;

  parent_index_table_core DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .target       (target),
    .other        (other),
    .done         (done),
    .ok           (ok),
    .result_index (result_index),
    .entry_count  (entry_count),
    .active_index (active_index)
  );

  // bounded walk up the parent chain looking for an entry
  function automatic bit chain_reaches(int from, int wanted);
    int p;
    int steps;
    p = from;
    steps = 0;
    while (p >= 0 && p < fcount && steps <= fcount) begin
      if (p == wanted) return 1'b1;
      p = int'(fparent[p]);
      steps++;
    end
    return 1'b0;
  endfunction

  // apply one request to the shadow forest and work out its result
  task automatic forest_apply(input logic [OP_W-1:0] o, input int t, input int x,
                              output outcome_t r);
    int  rp;
    int  q;
    int  res;
    bit  good;
    good = 1'b0;
    res = -1;
    case (o)
      OP_ADD: begin
        if (fcount < MAX_ENTRIES) begin
          fparent[fcount] = (x >= 0 && x < fcount) ? par_t'(x) : par_t'(-1);
          res = fcount;
          fcount++;
          good = 1'b1;
        end else begin
          full_refusals++;
        end
      end
      OP_REMOVE: begin
        if (t < fcount) begin
          rp = int'(fparent[t]);
          // children move to the removed entry's parent, higher links drop
          for (int i = 0; i < fcount; i++) begin
            q = int'(fparent[i]);
            if (q == t) fparent[i] = par_t'((rp > t) ? rp - 1 : rp);
            else if (q > t) fparent[i] = par_t'(q - 1);
          end
          for (int i = t; i + 1 < fcount; i++) fparent[i] = fparent[i + 1];
          fcount--;
          if (factive == t) factive = -1;
          else if (factive > t) factive--;
          good = 1'b1;
        end
      end
      OP_REPARENT: begin
        if (t < fcount && x >= -1 && x < fcount && x != t && !chain_reaches(x, t)) begin
          fparent[t] = par_t'(x);
          good = 1'b1;
        end else begin
          reparent_refusals++;
        end
      end
      OP_QUERY: begin
        if (x >= 0 && t < fcount) good = chain_reaches(int'(fparent[t]), x);
      end
      OP_SETACT: begin
        factive = (x < 0) ? -1 : x;
        good = 1'b1;
      end
      default: ;
    endcase
    if (fcount > peak_count) peak_count = fcount;
    r.ok  = good;
    r.res = par_t'(res);
    r.cnt = cnt_t'(fcount);
    r.act = par_t'(factive);
  endtask

  // hold the request until taken, then record what it should give
  task automatic issue(input logic [OP_W-1:0] o, input int t, input int x, input int gap,
                       input bit typed, input outcome_t want);
    outcome_t pred;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    op     <= o;
    target <= idx_t'(t);
    other  <= par_t'(x);
    do @(posedge clk); while (busy);
    forest_apply(o, t, x, pred);
    outcome_q.push_back(typed ? want : pred);
    requests++;
  endtask

  function automatic dir_row_t drow(logic [OP_W-1:0] o, int t, int x);
    drow.op    = o;
    drow.tgt   = t;
    drow.oth   = x;
    drow.typed = 1'b0;
    drow.want  = '0;
  endfunction

  function automatic dir_row_t trow(logic [OP_W-1:0] o, int t, int x,
                                    bit k, int r, int c, int a);
    trow.op       = o;
    trow.tgt      = t;
    trow.oth      = x;
    trow.typed    = 1'b1;
    trow.want.ok  = k;
    trow.want.res = par_t'(r);
    trow.want.cnt = cnt_t'(c);
    trow.want.act = par_t'(a);
  endfunction

  function automatic void field_diff(string name, integer want, integer got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // result checker
  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && done) begin
      if (outcome_q.size() == 0) begin
        errors++;
        $display("%0t ns: result with no request pending, expected none, got ok=%0d idx=%0d",
                 $time, ok, result_index);
      end else begin
        want = outcome_q.pop_front();
        field_diff("ok", integer'(want.ok), integer'(ok));
        field_diff("result_index", integer'(want.res), integer'(result_index));
        field_diff("entry_count", integer'(want.cnt), integer'(entry_count));
        field_diff("active_index", integer'(want.act), integer'(active_index));
      end
    end
  end

  initial begin : stimulus
    dir_row_t        rows[$];
    logic [OP_W-1:0] o;
    int              tv;
    int              xv;
    int              gap;
    int              n;
    int              mode;
    int              len;
    int              roll;
    int              wa;
    int              wr;
    int              wp;
    int              wq;
    int              waited;
    bit              idle_on;
    bit              first;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty table, active extremes, unknown ops
    rows.push_back(trow(OP_REMOVE, 0, 0, 0, -1, 0, -1));
    rows.push_back(trow(OP_QUERY, 0, 0, 0, -1, 0, -1));
    rows.push_back(trow(OP_REPARENT, 0, -1, 0, -1, 0, -1));
    rows.push_back(trow(OP_SETACT, 0, -64, 1, -1, 0, -1));
    rows.push_back(trow(OP_SETACT, 63, 63, 1, -1, 0, 63));
    rows.push_back(trow(OP_BAD_LO, 0, 0, 0, -1, 0, 63));
    rows.push_back(trow(OP_BAD_HI, 63, -1, 0, -1, 0, 63));
    // build a small forest, parents not earlier become roots
    rows.push_back(trow(OP_ADD, 0, -1, 1, 0, 1, 63));
    rows.push_back(trow(OP_ADD, 63, 1, 1, 1, 2, 63));
    rows.push_back(drow(OP_ADD, 0, 0));
    rows.push_back(trow(OP_ADD, 0, 63, 1, 3, 4, 63));
    rows.push_back(drow(OP_ADD, 0, 2));
    rows.push_back(trow(OP_SETACT, 0, 2, 1, -1, 5, 2));
    // queries, refused reparents and one accepted reparent
    rows.push_back(drow(OP_QUERY, 4, 0));
    rows.push_back(trow(OP_QUERY, 4, -1, 0, -1, 5, 2));
    rows.push_back(drow(OP_QUERY, 0, 4));
    rows.push_back(drow(OP_REPARENT, 0, 4));
    rows.push_back(drow(OP_REPARENT, 1, 1));
    rows.push_back(drow(OP_REPARENT, 1, 5));
    rows.push_back(drow(OP_REPARENT, 0, -2));
    rows.push_back(drow(OP_REPARENT, 3, 4));
    // removes: active entry, missing entry, active above removed
    rows.push_back(drow(OP_REMOVE, 2, 0));
    rows.push_back(drow(OP_REMOVE, 63, 0));
    rows.push_back(drow(OP_SETACT, 0, 3));
    rows.push_back(drow(OP_REMOVE, 0, 0));

    foreach (rows[i]) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 13) : 0;
      issue(rows[i].op, rows[i].tgt, rows[i].oth, gap, rows[i].typed, rows[i].want);
    end

    // random phases: grow, shrink or mixed, first one is a grow phase
    n = 0;
    first = 1'b1;
    while (n < RANDOM_REQUESTS) begin
      mode = first ? 0 : $urandom_range(0, 2);
      first = 1'b0;
      len = $urandom_range(30, 120);
      idle_on = ($urandom_range(0, 2) != 0);
      case (mode)
        0:       begin wa = 85; wr = 3;  wp = 5;  wq = 5;  end
        1:       begin wa = 15; wr = 55; wp = 12; wq = 12; end
        default: begin wa = 25; wr = 15; wp = 25; wq = 25; end
      endcase
      for (int k = 0; k < len && n < RANDOM_REQUESTS; k++) begin
        tv = (fcount > 0) ? $urandom_range(0, fcount - 1) : 0;
        xv = int'($urandom_range(0, fcount)) - 1;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          // noise over the whole field ranges
          o  = OP_W'($urandom_range(0, 7));
          tv = $urandom_range(0, 63);
          xv = int'($urandom_range(0, 127)) - 64;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < wa) o = OP_ADD;
          else if (roll < wa + wr) o = OP_REMOVE;
          else if (roll < wa + wr + wp) o = OP_REPARENT;
          else if (roll < wa + wr + wp + wq) o = OP_QUERY;
          else o = OP_SETACT;
          if (o == OP_SETACT && $urandom_range(0, 3) == 0) xv = $urandom_range(0, 63);
        end
        gap = 0;
        if (idle_on && n < RANDOM_REQUESTS - CALM_TAIL && $urandom_range(0, 3) == 0)
          gap = $urandom_range(1, 13);
        issue(o, tv, xv, gap, 1'b0, '0);
        n++;
      end
    end

    start <= 1'b0;
    waited = 0;
    while (outcome_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (outcome_q.size() != 0) begin
      errors++;
      $display("%0t ns: %0d results never arrived", $time, outcome_q.size());
    end
    repeat (10) @(posedge clk);

    $display("%0d requests sent; table peaked at %0d of %0d entries", requests, peak_count,
             MAX_ENTRIES);
    $display("%0d adds refused on a full table, %0d reparents refused", full_refusals,
             reparent_refusals);
    if (errors == 0) begin
      $display("tb_parent_index_table_core: PASS");
    end else begin
      $display("tb_parent_index_table_core: FAIL");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #15_000_000;
    $display("timeout at %0t ns", $time);
    $display("tb_parent_index_table_core: FAIL");
    $finish;
  end

endmodule

>>> sim.f
sv/pit_pkg.sv
sv/pit_cell.sv
sv/pit_row.sv
sv/parent_index_table_core.sv
test/tb_parent_index_table_core.sv
